@@ src/mrc_pkg.sv @@
`default_nettype none

package mrc_pkg;

  // default sizing
  localparam int MaxFrameBytes = 256;
  localparam int QueueDepth    = 4;

  // frame constants
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam int          RuntBytes = 4;
  localparam int          OverheadBytes = 4;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_SUCCESS    = 2'd0,
    OUT_RETRY      = 2'd1,
    OUT_FAILED_EXC = 2'd2,
    OUT_EXHAUSTED  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_TIMEOUT   = 3'd1,
    RSN_RUNT      = 3'd2,
    RSN_CRC       = 3'd3,
    RSN_ADDRESS   = 3'd4,
    RSN_EXCEPTION = 3'd5,
    RSN_FUNCTION  = 3'd6,
    RSN_LENGTH    = 3'd7
  } reason_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDRESS     = 2'd0,
    CFG_FUNCTION_CODE     = 2'd1,
    CFG_RESPONSE_PDU_SIZE = 2'd2,
    CFG_RETRY_LIMIT       = 2'd3
  } cfg_idx_t;

  // what the front hands to the back
  typedef enum logic [1:0] {
    KIND_START     = 2'd0,
    KIND_RETRYABLE = 2'd1,
    KIND_EXCEPTION = 2'd2,
    KIND_SUCCESS   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    reason_t     reason;
    logic [7:0]  exc_code;
  } verdict_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [6:0] function_code;
    logic [7:0] response_pdu_size;
  } frame_cfg_t;

  // one byte of reflected crc-16, unrolled over eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/mrc_queue.sv @@
`default_nettype none

module mrc_queue #(
  parameter int DEPTH = mrc_pkg::QueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire mrc_pkg::verdict_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output mrc_pkg::verdict_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrc_pkg::verdict_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill did not grow on push");

endmodule

`default_nettype wire

@@ src/mrc_front.sv @@
`default_nettype none

module mrc_front #(
  parameter int MAX_FRAME_BYTES = mrc_pkg::MaxFrameBytes
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mrc_pkg::frame_cfg_t cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_command,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_last_byte,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output mrc_pkg::verdict_t        push_data
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LEN_W = (CNT_W > 9) ? CNT_W : 9;

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       dly0_r, dly0_nxt, dly1_r, dly1_nxt;
  logic [7:0]       addr_r, addr_nxt, func_r, func_nxt, third_r, third_nxt;

  logic             accept;
  logic [15:0]      crc_upd;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       addr_new, func_new, third_new;
  logic [LEN_W-1:0] len_expect;
  logic             clear;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // per-byte frame updates, as seen after this byte
  assign crc_upd   = (cnt_r >= CNT_W'(2)) ? mrc_pkg::crc_byte(crc_r, dly0_r) : crc_r;
  assign cnt_inc   = (cnt_r <= CNT_W'(MAX_FRAME_BYTES)) ? cnt_r + 1'b1 : cnt_r;
  assign addr_new  = (cnt_r == CNT_W'(0)) ? in_data_byte : addr_r;
  assign func_new  = (cnt_r == CNT_W'(1)) ? in_data_byte : func_r;
  assign third_new = (cnt_r == CNT_W'(2)) ? in_data_byte : third_r;
  assign len_expect = LEN_W'(cfg.response_pdu_size) + LEN_W'(mrc_pkg::OverheadBytes);

  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    third_nxt = third_r;
    clear     = 1'b0;
    push_valid = 1'b0;
    push_data  = '{kind: mrc_pkg::KIND_START, reason: mrc_pkg::RSN_NONE, exc_code: 8'h00};

    if (accept) begin
      unique case (in_command)
        mrc_pkg::CMD_START: begin
          clear      = 1'b1;
          push_valid = 1'b1;
        end
        mrc_pkg::CMD_TIMEOUT: begin
          clear      = 1'b1;
          push_valid = 1'b1;
          push_data.kind   = mrc_pkg::KIND_RETRYABLE;
          push_data.reason = mrc_pkg::RSN_TIMEOUT;
        end
        mrc_pkg::CMD_BYTE: begin
          crc_nxt   = crc_upd;
          cnt_nxt   = cnt_inc;
          dly0_nxt  = dly1_r;
          dly1_nxt  = in_data_byte;
          addr_nxt  = addr_new;
          func_nxt  = func_new;
          third_nxt = third_new;
          if (in_last_byte) begin
            clear      = 1'b1;
            push_valid = 1'b1;
            push_data.kind = mrc_pkg::KIND_RETRYABLE;
            if (cnt_inc < CNT_W'(mrc_pkg::RuntBytes)) begin
              push_data.reason = mrc_pkg::RSN_RUNT;
            end else if (dly1_r != crc_upd[7:0] || in_data_byte != crc_upd[15:8]) begin
              push_data.reason = mrc_pkg::RSN_CRC;
            end else if (addr_new != cfg.slave_address) begin
              push_data.reason = mrc_pkg::RSN_ADDRESS;
            end else if (func_new == {1'b1, cfg.function_code}) begin
              push_data.kind     = mrc_pkg::KIND_EXCEPTION;
              push_data.reason   = mrc_pkg::RSN_EXCEPTION;
              push_data.exc_code = third_new;
            end else if (func_new != {1'b0, cfg.function_code}) begin
              push_data.reason = mrc_pkg::RSN_FUNCTION;
            end else if (cnt_inc > CNT_W'(MAX_FRAME_BYTES) ||
                         LEN_W'(cnt_inc) != len_expect) begin
              push_data.reason = mrc_pkg::RSN_LENGTH;
            end else begin
              push_data.kind = mrc_pkg::KIND_SUCCESS;
            end
          end
        end
        default: begin
          // unused command code, dropped
        end
      endcase
    end

    if (clear) begin
      crc_nxt   = mrc_pkg::CrcInit;
      cnt_nxt   = '0;
      dly0_nxt  = 8'h00;
      dly1_nxt  = 8'h00;
      addr_nxt  = 8'h00;
      func_nxt  = 8'h00;
      third_nxt = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= mrc_pkg::CrcInit;
      cnt_r   <= '0;
      dly0_r  <= 8'h00;
      dly1_r  <= 8'h00;
      addr_r  <= 8'h00;
      func_r  <= 8'h00;
      third_r <= 8'h00;
    end else begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      dly0_r  <= dly0_nxt;
      dly1_r  <= dly1_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      third_r <= third_nxt;
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME_BYTES + 1))
    else $error("byte count past saturation");

endmodule

`default_nettype wire

@@ src/mrc_back.sv @@
`default_nettype none

module mrc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [2:0]        retry_limit,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire mrc_pkg::verdict_t pop_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_outcome,
  output logic [2:0]             out_reason,
  output logic [7:0]             out_exception_code,
  output logic [2:0]             out_attempt_number
);

  logic [2:0]          used_r, used_nxt;
  logic                valid_r, valid_nxt;
  mrc_pkg::outcome_t   outcome_r, outcome_nxt;
  mrc_pkg::reason_t    reason_r, reason_nxt;
  logic [7:0]          exc_r, exc_nxt;
  logic [2:0]          attempt_r, attempt_nxt;
  logic                pop_fire;

  assign pop_ready = !valid_r || out_ready;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    used_nxt    = used_r;
    valid_nxt   = valid_r && !out_ready;
    outcome_nxt = outcome_r;
    reason_nxt  = reason_r;
    exc_nxt     = exc_r;
    attempt_nxt = attempt_r;
    if (pop_fire) begin
      reason_nxt  = pop_data.reason;
      exc_nxt     = 8'h00;
      attempt_nxt = used_r;
      unique case (pop_data.kind)
        mrc_pkg::KIND_START: begin
          used_nxt = 3'd0;
        end
        mrc_pkg::KIND_RETRYABLE: begin
          valid_nxt = 1'b1;
          if (used_r < retry_limit) begin
            outcome_nxt = mrc_pkg::OUT_RETRY;
            used_nxt    = used_r + 3'd1;
          end else begin
            outcome_nxt = mrc_pkg::OUT_EXHAUSTED;
          end
        end
        mrc_pkg::KIND_EXCEPTION: begin
          valid_nxt   = 1'b1;
          outcome_nxt = mrc_pkg::OUT_FAILED_EXC;
          exc_nxt     = pop_data.exc_code;
        end
        mrc_pkg::KIND_SUCCESS: begin
          valid_nxt   = 1'b1;
          outcome_nxt = mrc_pkg::OUT_SUCCESS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    reason_r  <= reason_nxt;
    exc_r     <= exc_nxt;
    attempt_r <= attempt_nxt;
  end

  assign out_valid          = valid_r;
  assign out_outcome        = outcome_r;
  assign out_reason         = reason_r;
  assign out_exception_code = exc_r;
  assign out_attempt_number = attempt_r;

  a_retry_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && outcome_r == mrc_pkg::OUT_RETRY) |-> (attempt_r < retry_limit))
    else $error("retry beat with attempt at or past limit");

  a_retry_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && pop_data.kind == mrc_pkg::KIND_RETRYABLE && used_r < retry_limit)
      |=> (used_r == $past(used_r) + 3'd1))
    else $error("attempt counter did not advance on retry");

endmodule

`default_nettype wire

@@ src/modbus_response_checker.sv @@
`default_nettype none

// modbus rtu response checker: takes one beat per cycle on the in_ channel (command start,
// received byte, or response timeout) and returns at most one verdict beat per input beat on
// the out_ channel. a front stage runs crc-16/modbus over the frame (one byte-wide unrolled
// crc update per beat, the last two bytes held back as the crc field), captures address,
// function and third byte, and judges the frame on the beat flagged last_byte in the order
// runt, crc, address, exception, function, length. a small verdict queue then feeds a back
// stage that keeps the attempt counter and applies the retry limit, with a registered output.
// sustained rate is one input beat per cycle; a verdict passes through the verdict queue
// and the back stage's output register to out_, and in_ready drops only when the queue is
// full. start and timeout beats discard any partial frame; a start also clears the attempt
// counter. configuration writes (cfg_index 0 slave address, 1 function code, 2 response pdu
// size, 3 retry limit) are always taken and must only be made while the block is idle.
module modbus_response_checker #(
  parameter int MAX_FRAME_BYTES = mrc_pkg::MaxFrameBytes,
  parameter int QUEUE_DEPTH     = mrc_pkg::QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // input beats
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  // verdict beats
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_outcome,
  output logic [2:0]      out_reason,
  output logic [7:0]      out_exception_code,
  output logic [2:0]      out_attempt_number
);

  // configuration registers
  mrc_pkg::frame_cfg_t frame_cfg_r, frame_cfg_nxt;
  logic [2:0]          retry_limit_r, retry_limit_nxt;

  // front to queue, queue to back
  logic              push_valid, push_ready;
  mrc_pkg::verdict_t push_data;
  logic              pop_valid, pop_ready;
  mrc_pkg::verdict_t pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    frame_cfg_nxt   = frame_cfg_r;
    retry_limit_nxt = retry_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrc_pkg::CFG_SLAVE_ADDRESS:     frame_cfg_nxt.slave_address     = cfg_data;
        mrc_pkg::CFG_FUNCTION_CODE:     frame_cfg_nxt.function_code     = cfg_data[6:0];
        mrc_pkg::CFG_RESPONSE_PDU_SIZE: frame_cfg_nxt.response_pdu_size = cfg_data;
        mrc_pkg::CFG_RETRY_LIMIT:       retry_limit_nxt                 = cfg_data[2:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cfg_r.slave_address     <= 8'd1;
      frame_cfg_r.function_code     <= 7'd3;
      frame_cfg_r.response_pdu_size <= 8'd4;
      retry_limit_r                 <= 3'd2;
    end else begin
      frame_cfg_r   <= frame_cfg_nxt;
      retry_limit_r <= retry_limit_nxt;
    end
  end

  // byte tracking, crc and frame classification
  mrc_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (frame_cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // verdicts in order, so front and back stall apart
  mrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // attempt accounting and output register
  mrc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .retry_limit        (retry_limit_r),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_data           (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_reason         (out_reason),
    .out_exception_code (out_exception_code),
    .out_attempt_number (out_attempt_number)
  );

endmodule

`default_nettype wire

@@ tb/tb_modbus_response_checker.sv @@
`timescale 1ns / 1ps

module tb_modbus_response_checker;
  import mrc_pkg::*;

  // run shape
  localparam int IdlePct     = 6;     // chance of an idle cycle on either side, in percent
  localparam int RandomBeats = 600;   // beats after the directed table
  localparam int PhaseBeats  = 60;    // beats between two register settings
  localparam int DrainCycles = 12;    // quiet cycles after the last verdict
  localparam int QuietLimit  = 2000;  // cycles with no beat anywhere before giving up

  // command value the block has no meaning for
  localparam logic [1:0] CmdUnused = 2'd3;

  // one verdict as it leaves the block
  typedef struct packed {
    outcome_t   outcome;
    reason_t    reason;
    logic [7:0] exc_code;
    logic [2:0] attempt;
  } judgement_t;

  localparam judgement_t NoWant = '0;

  // how a row of the directed table fills its data byte
  typedef enum logic [1:0] {
    ROW_LIT,      // data byte as written
    ROW_CRC_LO,   // low crc byte over the frame so far
    ROW_CRC_BAD,  // low crc byte, inverted
    ROW_CRC_HI    // high crc byte over the frame so far
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] cmd;
    logic [7:0] data;
    logic       last;
    logic       typed;  // verdict typed in below rather than predicted
    judgement_t want;
  } row_t;

  // random frame shapes
  typedef enum {
    FR_GOOD, FR_EXC, FR_BADCRC, FR_ADDR, FR_FUNC, FR_LEN, FR_RUNT, FR_CUT, FR_LONG
  } shape_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_command;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_outcome;
  logic [2:0] out_reason;
  logic [7:0] out_exception_code;
  logic [2:0] out_attempt_number;

  modbus_response_checker uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_reason         (out_reason),
    .out_exception_code (out_exception_code),
    .out_attempt_number (out_attempt_number)
  );

  // register copies, at their reset values
  logic [7:0] cfg_addr    = 8'd1;
  logic [6:0] cfg_func    = 7'd3;
  logic [7:0] cfg_pdu     = 8'd4;
  logic [2:0] cfg_retries = 3'd2;

  // frame and attempt state of the predictor
  logic [15:0] acc_crc   = CrcInit;
  int          nbytes    = 0;
  logic [7:0]  held [2]  = '{8'h00, 8'h00};
  logic [7:0]  seen_addr = 8'h00;
  logic [7:0]  seen_func = 8'h00;
  logic [7:0]  seen_third = 8'h00;
  logic [2:0]  tries     = 3'd0;

  judgement_t verdicts_due [$];  // verdicts predicted and not yet seen
  judgement_t head;
  int         errors       = 0;
  int         quiet        = 0;
  int         random_beats = 0;
  bit         calm         = 1'b0;  // no idling on either side
  bit         tally        = 1'b0;  // count beats toward the random total

  // reflected crc-16, input bit by input bit
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic void wipe_frame();
    acc_crc    = CrcInit;
    nbytes     = 0;
    held[0]    = 8'h00;
    held[1]    = 8'h00;
    seen_addr  = 8'h00;
    seen_func  = 8'h00;
    seen_third = 8'h00;
  endfunction

  // failed attempt: retry while the limit allows, else exhausted with the count held
  function automatic judgement_t charge_failure(input reason_t why);
    judgement_t v;
    if (tries < cfg_retries) begin
      v = '{OUT_RETRY, why, 8'h00, tries};
      tries++;
    end else begin
      v = '{OUT_EXHAUSTED, why, 8'h00, tries};
    end
    return v;
  endfunction

  // predicted verdict for one accepted input beat, if it causes one
  function automatic void judge_beat(input logic [1:0] c, input logic [7:0] d, input logic l,
                                     output bit got, output judgement_t v);
    got = 1'b0;
    v   = NoWant;
    case (c)
      CMD_START: begin
        wipe_frame();
        tries = 3'd0;
      end
      CMD_TIMEOUT: begin
        wipe_frame();
        v   = charge_failure(RSN_TIMEOUT);
        got = 1'b1;
      end
      CMD_BYTE: begin
        if (nbytes == 0) seen_addr = d;
        else if (nbytes == 1) seen_func = d;
        else if (nbytes == 2) seen_third = d;
        // crc trails two bytes behind, the last two being the crc field itself
        if (nbytes >= 2) acc_crc = crc_step(acc_crc, held[0]);
        held[0] = held[1];
        held[1] = d;
        if (nbytes <= MaxFrameBytes) nbytes++;
        if (l) begin
          got = 1'b1;
          if (nbytes < RuntBytes) v = charge_failure(RSN_RUNT);
          else if ({held[1], held[0]} != acc_crc) v = charge_failure(RSN_CRC);
          else if (seen_addr != cfg_addr) v = charge_failure(RSN_ADDRESS);
          else if (seen_func == {1'b1, cfg_func})
            v = '{OUT_FAILED_EXC, RSN_EXCEPTION, seen_third, tries};
          else if (seen_func != {1'b0, cfg_func}) v = charge_failure(RSN_FUNCTION);
          else if (nbytes > MaxFrameBytes || nbytes != int'(cfg_pdu) + OverheadBytes)
            v = charge_failure(RSN_LENGTH);
          else v = '{OUT_SUCCESS, RSN_NONE, 8'h00, tries};
          wipe_frame();
        end
      end
      default: begin
        // unused command, nothing happens
      end
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side stalls
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // verdict checking, field by field against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict outcome %0d reason %0d exc %0h attempt %0d",
                 $time, out_outcome, out_reason, out_exception_code, out_attempt_number);
        errors++;
      end else begin
        head = verdicts_due.pop_front();
        if (out_outcome !== head.outcome) begin
          $display("%0t: outcome expected %0d, got %0d", $time, head.outcome, out_outcome);
          errors++;
        end
        if (out_reason !== head.reason) begin
          $display("%0t: reason expected %0d, got %0d", $time, head.reason, out_reason);
          errors++;
        end
        if (out_exception_code !== head.exc_code) begin
          $display("%0t: exception code expected %0h, got %0h",
                   $time, head.exc_code, out_exception_code);
          errors++;
        end
        if (out_attempt_number !== head.attempt) begin
          $display("%0t: attempt expected %0d, got %0d",
                   $time, head.attempt, out_attempt_number);
          errors++;
        end
      end
    end
  end

  // watchdog: any accepted beat on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QuietLimit) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input beat; valid stays high across back-to-back beats
  task automatic put_beat(input logic [1:0] c, input logic [7:0] d, input logic l,
                          input bit typed, input judgement_t want);
    bit         got;
    judgement_t v;
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= c;
    in_data_byte <= d;
    in_last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    judge_beat(c, d, l, got, v);
    if (typed) v = want;
    if (got) verdicts_due.push_back(v);
    if (tally) random_beats++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SLAVE_ADDRESS:     cfg_addr    = val;
      CFG_FUNCTION_CODE:     cfg_func    = val[6:0];
      CFG_RESPONSE_PDU_SIZE: cfg_pdu     = val;
      default:               cfg_retries = val[2:0];
    endcase
  endtask

  task automatic load_settings(input logic [7:0] a, input logic [6:0] f,
                               input logic [7:0] p, input logic [2:0] r);
    write_reg(CFG_SLAVE_ADDRESS, a);
    write_reg(CFG_FUNCTION_CODE, {1'b0, f});
    write_reg(CFG_RESPONSE_PDU_SIZE, p);
    write_reg(CFG_RETRY_LIMIT, {5'd0, r});
    cfg_valid <= 1'b0;
  endtask

  // wait for every verdict, then let any beat that makes none work its way through
  task automatic settle();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one frame built to hit a given check, sent byte by byte
  task automatic send_frame(input shape_t k);
    logic [7:0]  fb [$];
    logic [7:0]  f;
    logic [15:0] crc;
    int          n;
    int          cut;
    fb  = {};
    cut = 0;
    if (k == FR_RUNT) begin
      n = $urandom_range(1, 3);
      repeat (n) fb.push_back(8'($urandom));
    end else begin
      fb.push_back(k == FR_ADDR ? cfg_addr ^ 8'($urandom_range(1, 255)) : cfg_addr);
      case (k)
        FR_EXC:  f = {1'b1, cfg_func};
        FR_FUNC: begin
          do f = 8'($urandom); while (f[6:0] == cfg_func);
        end
        default: f = {1'b0, cfg_func};
      endcase
      fb.push_back(f);
      case (k)
        FR_EXC:  n = $urandom_range(0, 2);  // short exception bodies, crc byte may be third
        FR_LEN: begin
          do n = $urandom_range(0, int'(cfg_pdu) + 3); while (n == int'(cfg_pdu));
        end
        FR_LONG: n = $urandom_range(253, 258);  // past the byte counter's saturation
        default: n = cfg_pdu;
      endcase
      repeat (n) fb.push_back(8'($urandom));
      crc = CrcInit;
      foreach (fb[i]) crc = crc_step(crc, fb[i]);
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      // any single flipped bit breaks the crc
      if (k == FR_BADCRC) begin
        n = $urandom_range(0, fb.size() - 1);
        fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (k == FR_CUT) cut = $urandom_range(1, fb.size() - 1);
    end
    if (cut != 0) begin
      // partial frame thrown away by a timeout
      for (int i = 0; i < cut; i++) put_beat(CMD_BYTE, fb[i], 1'b0, 1'b0, NoWant);
      put_beat(CMD_TIMEOUT, 8'($urandom), 1'($urandom), 1'b0, NoWant);
    end else begin
      foreach (fb[i]) put_beat(CMD_BYTE, fb[i], i == fb.size() - 1, 1'b0, NoWant);
    end
  endtask

  row_t plan [0:29];

  initial begin
    logic [15:0] tbl_crc;
    logic [7:0]  b;
    int          goal;
    int          r;

    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SLAVE_ADDRESS;
    cfg_data     = 8'h00;
    in_valid     = 1'b0;
    in_command   = CMD_START;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    out_ready    = 1'b0;

    // directed beats at reset settings: address 1, function 3, pdu 4, retry limit 2
    plan = '{
      // timeout straight out of reset
      '{ROW_LIT, CMD_TIMEOUT, 8'h00, 1'b0, 1'b1, '{OUT_RETRY, RSN_TIMEOUT, 8'h00, 3'd0}},
      // start with stray byte fields, clears the attempt count
      '{ROW_LIT, CMD_START, 8'hff, 1'b1, 1'b0, NoWant},
      // single byte frame
      '{ROW_LIT, CMD_BYTE, 8'h01, 1'b1, 1'b1, '{OUT_RETRY, RSN_RUNT, 8'h00, 3'd0}},
      // good frame, payload bytes at the extremes
      '{ROW_LIT, CMD_BYTE, 8'h01, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h03, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'hff, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h80, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h7f, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_LO, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_HI, CMD_BYTE, 8'h00, 1'b1, 1'b1, '{OUT_SUCCESS, RSN_NONE, 8'h00, 3'd1}},
      // exception response, fatal, count untouched
      '{ROW_LIT, CMD_BYTE, 8'h01, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h83, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'hab, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_LO, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_HI, CMD_BYTE, 8'h00, 1'b1, 1'b1,
        '{OUT_FAILED_EXC, RSN_EXCEPTION, 8'hab, 3'd1}},
      // unused command is dropped
      '{ROW_LIT, CmdUnused, 8'hff, 1'b1, 1'b0, NoWant},
      // corrupted crc field
      '{ROW_LIT, CMD_BYTE, 8'h01, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h03, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_BAD, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_HI, CMD_BYTE, 8'h00, 1'b1, 1'b1, '{OUT_RETRY, RSN_CRC, 8'h00, 3'd1}},
      // wrong slave, limit reached
      '{ROW_LIT, CMD_BYTE, 8'h02, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h03, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_LO, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_HI, CMD_BYTE, 8'h00, 1'b1, 1'b1, '{OUT_EXHAUSTED, RSN_ADDRESS, 8'h00, 3'd2}},
      // wrong function, still exhausted
      '{ROW_LIT, CMD_BYTE, 8'h01, 1'b0, 1'b0, NoWant},
      '{ROW_LIT, CMD_BYTE, 8'h05, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_LO, CMD_BYTE, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CRC_HI, CMD_BYTE, 8'h00, 1'b1, 1'b1, '{OUT_EXHAUSTED, RSN_FUNCTION, 8'h00, 3'd2}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // walk the table, keeping a crc over the bytes of the frame in flight
    tbl_crc = CrcInit;
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CRC_LO:  b = tbl_crc[7:0];
        ROW_CRC_BAD: b = ~tbl_crc[7:0];
        ROW_CRC_HI:  b = tbl_crc[15:8];
        default:     b = plan[i].data;
      endcase
      put_beat(plan[i].cmd, b, plan[i].last, plan[i].typed, plan[i].want);
      if (plan[i].cmd != CMD_BYTE || plan[i].last) tbl_crc = CrcInit;
      else if (plan[i].kind == ROW_LIT) tbl_crc = crc_step(tbl_crc, b);
    end
    settle();

    // random part, one register setting per phase
    for (int phase = 0; random_beats < RandomBeats; phase++) begin
      case (phase)
        0:       load_settings(8'hff, 7'h7f, 8'd253, 3'd7);
        1:       load_settings(8'h00, 7'h00, 8'd0, 3'd0);
        default: load_settings(8'($urandom), 7'($urandom), 8'($urandom_range(0, 8)),
                               3'($urandom));
      endcase
      calm  = (phase == 2);
      tally = 1'b1;
      if (phase == 0) begin
        // frame of the configured size, one byte past the largest legal frame, then a long one
        send_frame(FR_GOOD);
        send_frame(FR_LONG);
      end else begin
        // limit now below the attempts already used
        if (phase == 1) send_frame(FR_BADCRC);
        goal = random_beats + PhaseBeats;
        while (random_beats < goal) begin
          r = $urandom_range(0, 99);
          if (r < 5) put_beat(CMD_START, 8'($urandom), 1'($urandom), 1'b0, NoWant);
          else if (r < 10) put_beat(CMD_TIMEOUT, 8'($urandom), 1'($urandom), 1'b0, NoWant);
          else if (r < 18) put_beat(2'($urandom), 8'($urandom), 1'($urandom), 1'b0, NoWant);
          else if (r < 40) send_frame(FR_GOOD);
          else if (r < 50) send_frame(FR_EXC);
          else if (r < 58) send_frame(FR_BADCRC);
          else if (r < 66) send_frame(FR_ADDR);
          else if (r < 74) send_frame(FR_FUNC);
          else if (r < 84) send_frame(FR_LEN);
          else if (r < 92) send_frame(FR_RUNT);
          else send_frame(FR_CUT);
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
